// ----- hw/rtl/bmprle8_pkg.sv -----
// ----------------------------------------------------------------------------
// bmprle8_pkg
// Shared types and constants for the BMP RLE8 span decoder.
// ----------------------------------------------------------------------------
package bmprle8_pkg;

    localparam int DIM_BITS = 13;
    localparam int CFG_INDEX_BITS = 1;

    typedef logic [DIM_BITS-1:0] dim_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    // Register indexes of the configuration port
    localparam cfg_index_t CFG_IDX_WIDTH  = 1'd0;
    localparam cfg_index_t CFG_IDX_HEIGHT = 1'd1;

    localparam dim_t WIDTH_RESET  = 13'd640;
    localparam dim_t HEIGHT_RESET = 13'd480;

    // Second byte of an escape (first byte zero)
    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       start_of_image;
    } item_t;

    typedef struct packed {
        dim_t       start_row;
        dim_t       start_col;
        dim_t       end_row;
        dim_t       end_col;
        logic [7:0] fill_value;
        logic       clipped;
        logic       end_of_image;
    } cmd_t;

    typedef struct packed {
        logic image_done;
        logic cmd_valid;
    } core_status_t;

endpackage

// ----- hw/rtl/bmprle8_in_stage.sv -----
// ----------------------------------------------------------------------------
// bmprle8_in_stage
// Input register: holds one accepted word until the parser consumes it.
// ----------------------------------------------------------------------------
module bmprle8_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bmprle8_pkg::item_t  s_item,
    input  logic                fire,
    output logic                in_valid,
    output bmprle8_pkg::item_t  in_item
);
    import bmprle8_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register frees up in the same cycle that the parser takes its word.
    assign s_ready    = !valid_reg || fire;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (fire ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign in_valid = valid_reg;
    assign in_item  = item_reg;

endmodule

// ----- hw/rtl/bmprle8_core.sv -----
// ----------------------------------------------------------------------------
// bmprle8_core
// RLE8 parser and cursor: turns one code byte into at most one fill span.
// ----------------------------------------------------------------------------
module bmprle8_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       fire,
    input  bmprle8_pkg::item_t         item,
    input  bmprle8_pkg::dim_t          image_width,
    input  bmprle8_pkg::dim_t          image_height,
    output logic                       cmd_valid,
    output bmprle8_pkg::cmd_t          cmd,
    output bmprle8_pkg::core_status_t  status
);
    import bmprle8_pkg::*;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_DX,
        PH_DY,
        PH_LIT,
        PH_PAD
    } phase_t;

    phase_t     phase_reg, phase_next, phase_e;
    logic [7:0] saved_first_reg, saved_first_next, saved_first_e;
    logic [7:0] lit_left_reg, lit_left_next, lit_left_e, lit_dec;
    logic       pad_reg, pad_next, pad_e;
    logic [7:0] saved_dx_reg, saved_dx_next, saved_dx_e;
    dim_t       row_reg, row_next, row_e;
    dim_t       col_reg, col_next, col_e;
    logic       done_reg, done_next, done_e;

    logic [7:0] b;
    logic       soi;

    // Run target
    logic [7:0]          run_len;
    logic [DIM_BITS:0]   run_sum;
    logic                run_off;
    logic                run_over;
    dim_t                run_col;
    logic                run_clip;

    // Delta target
    logic [DIM_BITS:0]   dly_row;
    logic [DIM_BITS:0]   dly_col;

    // Span request
    logic       span_do;
    logic       span_force;
    logic       span_clip;
    logic       span_eoi;
    logic       span_eol;
    logic [7:0] span_val;
    dim_t       tgt_row;
    dim_t       tgt_col;

    // Raster distance from cursor to target
    logic signed [DIM_BITS:0]     span_dr;
    logic signed [DIM_BITS:0]     span_dc;
    logic signed [DIM_BITS:0]     width_s;
    logic signed [2*DIM_BITS+1:0] span_prod;
    logic signed [2*DIM_BITS+1:0] span_dist;
    logic       behind;
    logic       same;
    dim_t       end_row;
    dim_t       end_col;
    logic       emit;

    assign b   = item.code_byte;
    assign soi = item.start_of_image;

    // A start-of-image word sees the parser as if freshly reset.
    assign phase_e       = soi ? PH_FIRST : phase_reg;
    assign saved_first_e = soi ? 8'd0 : saved_first_reg;
    assign lit_left_e    = soi ? 8'd0 : lit_left_reg;
    assign pad_e         = soi ? 1'b0 : pad_reg;
    assign saved_dx_e    = soi ? 8'd0 : saved_dx_reg;
    assign row_e         = soi ? '0 : row_reg;
    assign col_e         = soi ? '0 : col_reg;
    assign done_e        = soi ? 1'b0 : done_reg;

    assign run_len  = (phase_e == PH_LIT) ? 8'd1 : saved_first_e;
    assign run_sum  = {1'b0, col_e} + {{(DIM_BITS-7){1'b0}}, run_len};
    assign run_off  = (row_e >= image_height) || (col_e >= image_width);
    assign run_over = run_sum > {1'b0, image_width};
    assign run_col  = run_off ? col_e : (run_over ? image_width : run_sum[DIM_BITS-1:0]);
    assign run_clip = run_off || run_over;

    assign dly_row = {1'b0, row_e} + {{(DIM_BITS-7){1'b0}}, b};
    assign dly_col = {1'b0, col_e} + {{(DIM_BITS-7){1'b0}}, saved_dx_e};

    assign lit_dec = lit_left_e - {7'd0, (lit_left_e != 8'd0)};

    always_comb begin
        phase_next       = phase_e;
        saved_first_next = saved_first_e;
        lit_left_next    = lit_left_e;
        pad_next         = pad_e;
        saved_dx_next    = saved_dx_e;
        done_next        = done_e;
        span_do          = 1'b0;
        span_force       = 1'b0;
        span_clip        = 1'b0;
        span_eoi         = 1'b0;
        span_eol         = 1'b0;
        span_val         = 8'd0;
        tgt_row          = row_e;
        tgt_col          = col_e;
        if (!done_e) begin
            unique case (phase_e)
                PH_FIRST: begin
                    saved_first_next = b;
                    phase_next       = PH_SECOND;
                end
                PH_SECOND: begin
                    phase_next = PH_FIRST;
                    if (saved_first_e != 8'd0) begin
                        span_do   = 1'b1;
                        span_val  = b;
                        span_clip = run_clip;
                        tgt_col   = run_col;
                    end else begin
                        case (b)
                            ESC_EOL: begin
                                if (row_e < image_height) begin
                                    span_do  = 1'b1;
                                    span_eol = 1'b1;
                                    tgt_col  = image_width;
                                end
                            end
                            ESC_EOB: begin
                                done_next  = 1'b1;
                                span_do    = 1'b1;
                                span_force = 1'b1;
                                span_eoi   = 1'b1;
                                if (row_e < image_height) begin
                                    tgt_row = image_height;
                                    tgt_col = '0;
                                end
                            end
                            ESC_DELTA: begin
                                phase_next = PH_DX;
                            end
                            default: begin
                                lit_left_next = b;
                                pad_next      = b[0];
                                phase_next    = PH_LIT;
                            end
                        endcase
                    end
                end
                PH_DX: begin
                    saved_dx_next = b;
                    phase_next    = PH_DY;
                end
                PH_DY: begin
                    phase_next = PH_FIRST;
                    span_do    = 1'b1;
                    if (dly_row >= {1'b0, image_height}) begin
                        tgt_row   = image_height;
                        tgt_col   = '0;
                        span_clip = 1'b1;
                    end else if (dly_col > {1'b0, image_width}) begin
                        tgt_row   = dly_row[DIM_BITS-1:0];
                        tgt_col   = image_width;
                        span_clip = 1'b1;
                    end else begin
                        tgt_row = dly_row[DIM_BITS-1:0];
                        tgt_col = dly_col[DIM_BITS-1:0];
                    end
                end
                PH_LIT: begin
                    lit_left_next = lit_dec;
                    if (lit_dec == 8'd0) begin
                        phase_next = pad_e ? PH_PAD : PH_FIRST;
                    end
                    span_do   = 1'b1;
                    span_val  = b;
                    span_clip = run_clip;
                    tgt_col   = run_col;
                end
                PH_PAD: begin
                    pad_next   = 1'b0;
                    phase_next = PH_FIRST;
                end
                default: begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    // Signed raster distance (target - cursor); a negative one can only come
    // from a size change in the middle of an image, and then the span collapses.
    assign span_dr   = $signed({1'b0, tgt_row}) - $signed({1'b0, row_e});
    assign span_dc   = $signed({1'b0, tgt_col}) - $signed({1'b0, col_e});
    assign width_s   = $signed({1'b0, image_width});
    assign span_prod = (2*DIM_BITS+2)'(span_dr) * (2*DIM_BITS+2)'(width_s);
    assign span_dist = span_prod + (2*DIM_BITS+2)'(span_dc);
    assign behind    = span_dist[2*DIM_BITS+1];
    assign same      = (span_dist == '0);
    assign end_row   = behind ? row_e : tgt_row;
    assign end_col   = behind ? col_e : tgt_col;
    assign emit      = span_do && (span_force || span_clip || (!behind && !same));

    always_comb begin
        row_next = row_e;
        col_next = col_e;
        if (span_do) begin
            if (span_eol) begin
                row_next = row_e + dim_t'(1);
                col_next = '0;
            end else begin
                row_next = end_row;
                col_next = end_col;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_FIRST;
            saved_first_reg <= 8'd0;
            lit_left_reg    <= 8'd0;
            pad_reg         <= 1'b0;
            saved_dx_reg    <= 8'd0;
            row_reg         <= '0;
            col_reg         <= '0;
            done_reg        <= 1'b0;
        end else if (fire) begin
            phase_reg       <= phase_next;
            saved_first_reg <= saved_first_next;
            lit_left_reg    <= lit_left_next;
            pad_reg         <= pad_next;
            saved_dx_reg    <= saved_dx_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            done_reg        <= done_next;
        end
    end

    assign cmd_valid        = fire && emit;
    assign cmd.start_row    = row_e;
    assign cmd.start_col    = col_e;
    assign cmd.end_row      = end_row;
    assign cmd.end_col      = end_col;
    assign cmd.fill_value   = span_val;
    assign cmd.clipped      = span_clip;
    assign cmd.end_of_image = span_eoi;

    assign status.image_done = done_reg;
    assign status.cmd_valid  = cmd_valid;

endmodule

// ----- hw/rtl/bmprle8_out_stage.sv -----
// ----------------------------------------------------------------------------
// bmprle8_out_stage
// Result register: holds one fill command until the sink takes it.
// ----------------------------------------------------------------------------
module bmprle8_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  bmprle8_pkg::cmd_t  cmd,
    input  logic               m_ready,
    output logic               m_valid,
    output bmprle8_pkg::cmd_t  m_cmd
);
    import bmprle8_pkg::*;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;

    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            cmd_reg <= cmd;
        end
    end

    assign m_valid = valid_reg;
    assign m_cmd   = cmd_reg;

endmodule

// ----- hw/rtl/bmp_rle8_decoder.sv -----
// ----------------------------------------------------------------------------
// bmp_rle8_decoder
// A fill command reaches the result port from its accepted code byte through
// the input register, then the parser into the result register.
// Throughput: one code byte per cycle while the result port is not stalled; the
// cursor update and the raster distance multiply are combinational between them.
// Reset: synchronous, active low; width 640, height 480, parser at first byte.
// ----------------------------------------------------------------------------
module bmp_rle8_decoder (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  bmprle8_pkg::cfg_index_t   cfg_index,
    input  logic [12:0]               cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_code_byte,
    input  logic                      s_start_of_image,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [12:0]               m_start_row,
    output logic [12:0]               m_start_col,
    output logic [12:0]               m_end_row,
    output logic [12:0]               m_end_col,
    output logic [7:0]                m_fill_value,
    output logic                      m_clipped,
    output logic                      m_end_of_image
);
    import bmprle8_pkg::*;

    dim_t         width_reg;
    dim_t         height_reg;
    item_t        s_item;
    item_t        in_item;
    logic         in_valid;
    logic         fire;
    logic         cmd_valid;
    cmd_t         cmd;
    cmd_t         m_cmd;
    core_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IDX_WIDTH:  width_reg  <= cfg_wdata;
                CFG_IDX_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_item.code_byte      = s_code_byte;
    assign s_item.start_of_image = s_start_of_image;

    // The parser takes a word whenever the result register can take its answer.
    assign fire = in_valid && (!m_valid || m_ready);

    bmprle8_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .fire     (fire),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    bmprle8_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .item         (in_item),
        .image_width  (width_reg),
        .image_height (height_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .status       (status)
    );

    bmprle8_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (cmd_valid),
        .cmd     (cmd),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_cmd   (m_cmd)
    );

    assign m_start_row    = m_cmd.start_row;
    assign m_start_col    = m_cmd.start_col;
    assign m_end_row      = m_cmd.end_row;
    assign m_end_col      = m_cmd.end_col;
    assign m_fill_value   = m_cmd.fill_value;
    assign m_clipped      = m_cmd.clipped;
    assign m_end_of_image = m_cmd.end_of_image;

`ifndef NO_ASSERTIONS
    // A stalled result must never be overwritten by the parser.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !fire)
        else $error("parser fired while the result register was stalled");

    // After end of bitmap nothing is produced until the next start of image.
    a_quiet_after_eob: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && status.image_done && !in_item.start_of_image |-> !status.cmd_valid)
        else $error("command produced after end of bitmap");

    // An ordinary command always covers at least one pixel.
    a_nonempty_span: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid && !cmd.clipped && !cmd.end_of_image |->
            (cmd.start_row != cmd.end_row) || (cmd.start_col != cmd.end_col))
        else $error("empty span emitted without clip or end of bitmap");

    // An empty input register always accepts a word.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid |-> s_ready)
        else $error("input refused while its register was empty");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the BMP RLE8 span decoder against a software decoder of its own.
// Directed code sequences cover the clipping, end-of-line, delta, literal and
// end-of-bitmap cases, including a size change part-way through an image.
// Random code streams then run under several image sizes and with idle and
// stall patterns on both channels. Every fill command is compared field by
// field with the decoder's prediction.
// ----------------------------------------------------------------------------
module testbench;
    import bmprle8_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int WORDS_PER_PHASE = 64;

    typedef enum logic [2:0] {
        ST_CODE, ST_ARG, ST_DX, ST_DY, ST_LITERAL, ST_PAD
    } dec_state_t;

    typedef enum int {
        IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
    } idle_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    cfg_index_t  cfg_index = CFG_IDX_WIDTH;
    logic [12:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_code_byte = '0;
    logic        s_start_of_image = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [12:0] m_start_row;
    logic [12:0] m_start_col;
    logic [12:0] m_end_row;
    logic [12:0] m_end_col;
    logic [7:0]  m_fill_value;
    logic        m_clipped;
    logic        m_end_of_image;

    bmp_rle8_decoder u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_code_byte      (s_code_byte),
        .s_start_of_image (s_start_of_image),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_start_row      (m_start_row),
        .m_start_col      (m_start_col),
        .m_end_row        (m_end_row),
        .m_end_col        (m_end_col),
        .m_fill_value     (m_fill_value),
        .m_clipped        (m_clipped),
        .m_end_of_image   (m_end_of_image)
    );

    always #1 aclk = ~aclk;

    // Decoder state as the testbench sees it
    int unsigned img_w = WIDTH_RESET;
    int unsigned img_h = HEIGHT_RESET;
    dec_state_t  st = ST_CODE;
    logic [7:0]  lead_byte = '0;
    int unsigned lit_count = 0;
    bit          pad_owed = 1'b0;
    logic [7:0]  delta_dx = '0;
    int unsigned row_pos = 0;
    int unsigned col_pos = 0;
    bit          eob_seen = 1'b0;

    cmd_t pending_fills[$];

    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    bit          soi_next = 1'b0;
    int unsigned live_words = 0;
    int unsigned fills_seen = 0;
    int unsigned clipped_seen = 0;
    int unsigned eoi_seen = 0;
    int unsigned size_settings = 0;
    int unsigned faults = 0;
    int unsigned quiet_cycles = 0;

    function automatic void restart_image();
        st = ST_CODE;
        lead_byte = '0;
        lit_count = 0;
        pad_owed = 1'b0;
        delta_dx = '0;
        row_pos = 0;
        col_pos = 0;
        eob_seen = 1'b0;
    endfunction

    function automatic longint unsigned raster_pos(int unsigned r, int unsigned c);
        return 64'(r) * 64'(img_w) + 64'(c);
    endfunction

    // Fill from the cursor up to (er, ec) and move the cursor there.
    function automatic bit span_to(int unsigned er, int unsigned ec, logic [7:0] val,
                                   bit clip, bit eoi, bit forced, output cmd_t cmd);
        int unsigned sr;
        int unsigned sc;
        sr = row_pos;
        sc = col_pos;
        cmd = '0;
        // After a width change the end may fall behind the start.
        if (raster_pos(er, ec) < raster_pos(sr, sc)) begin
            er = sr;
            ec = sc;
        end
        row_pos = er & 32'h1fff;
        col_pos = ec & 32'h1fff;
        if (!forced && !clip && raster_pos(er, ec) == raster_pos(sr, sc))
            return 1'b0;
        cmd.start_row = dim_t'(sr);
        cmd.start_col = dim_t'(sc);
        cmd.end_row = dim_t'(er);
        cmd.end_col = dim_t'(ec);
        cmd.fill_value = val;
        cmd.clipped = clip;
        cmd.end_of_image = eoi;
        return 1'b1;
    endfunction

    function automatic bit run_span(int unsigned n, logic [7:0] val, output cmd_t cmd);
        if (row_pos >= img_h || col_pos >= img_w)
            return span_to(row_pos, col_pos, val, 1'b1, 1'b0, 1'b0, cmd);
        if (col_pos + n > img_w)
            return span_to(row_pos, img_w, val, 1'b1, 1'b0, 1'b0, cmd);
        return span_to(row_pos, col_pos + n, val, 1'b0, 1'b0, 1'b0, cmd);
    endfunction

    // Advances the decoder by one code byte; returns 1 when a fill is due.
    function automatic bit decode_byte(logic [7:0] b, logic soi, output cmd_t cmd);
        int unsigned tr;
        int unsigned tc;
        bit clip;
        bit hit;
        cmd = '0;
        if (soi)
            restart_image();
        if (eob_seen)
            return 1'b0;
        case (st)
            ST_CODE: begin
                lead_byte = b;
                st = ST_ARG;
                return 1'b0;
            end
            ST_ARG: begin
                st = ST_CODE;
                if (lead_byte != 8'd0)
                    return run_span(lead_byte, b, cmd);
                if (b == ESC_EOL) begin
                    if (row_pos >= img_h)
                        return 1'b0;
                    tr = row_pos;
                    hit = span_to(tr, img_w, 8'd0, 1'b0, 1'b0, 1'b0, cmd);
                    row_pos = (tr + 1) & 32'h1fff;
                    col_pos = 0;
                    return hit;
                end
                if (b == ESC_EOB) begin
                    eob_seen = 1'b1;
                    if (row_pos >= img_h)
                        return span_to(row_pos, col_pos, 8'd0, 1'b0, 1'b1, 1'b1, cmd);
                    return span_to(img_h, 0, 8'd0, 1'b0, 1'b1, 1'b1, cmd);
                end
                if (b == ESC_DELTA) begin
                    st = ST_DX;
                    return 1'b0;
                end
                lit_count = b;
                pad_owed = b[0];
                st = ST_LITERAL;
                return 1'b0;
            end
            ST_DX: begin
                delta_dx = b;
                st = ST_DY;
                return 1'b0;
            end
            ST_DY: begin
                st = ST_CODE;
                tr = row_pos + b;
                tc = col_pos + delta_dx;
                clip = 1'b0;
                if (tr >= img_h) begin
                    tr = img_h;
                    tc = 0;
                    clip = 1'b1;
                end else if (tc > img_w) begin
                    tc = img_w;
                    clip = 1'b1;
                end
                return span_to(tr, tc, 8'd0, clip, 1'b0, 1'b0, cmd);
            end
            ST_LITERAL: begin
                if (lit_count > 0)
                    lit_count--;
                if (lit_count == 0)
                    st = pad_owed ? ST_PAD : ST_CODE;
                return run_span(1, b, cmd);
            end
            ST_PAD: begin
                pad_owed = 1'b0;
                st = ST_CODE;
                return 1'b0;
            end
            default: begin
                st = ST_CODE;
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic string fill_text(cmd_t c);
        return $sformatf("(%0d,%0d)..(%0d,%0d) val=%02h clip=%0b eoi=%0b",
                         c.start_row, c.start_col, c.end_row, c.end_col,
                         c.fill_value, c.clipped, c.end_of_image);
    endfunction

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                src_idle_pct = 0;
                sink_stall_pct = 0;
            end
            IDLE_SENDER: begin
                src_idle_pct = 54;
                sink_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                src_idle_pct = 0;
                sink_stall_pct = 54;
            end
            default: begin
                src_idle_pct = 10;
                sink_stall_pct = 10;
            end
        endcase
    endtask

    // Sends one word; the start-of-image flag is taken from soi_next.
    task automatic send_byte(input logic [7:0] b);
        cmd_t cmd;
        logic soi;
        soi = soi_next;
        soi_next = 1'b0;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_code_byte <= b;
        s_start_of_image <= soi;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (soi || !eob_seen)
            live_words++;
        if (decode_byte(b, soi, cmd))
            pending_fills.push_back(cmd);
    endtask

    task automatic send_pair(input logic [7:0] a, input logic [7:0] b);
        send_byte(a);
        send_byte(b);
    endtask

    // Waits until every expected fill has arrived and the pipeline is empty.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_fills.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_dims(input int unsigned w, input int unsigned h);
        cfg_we <= 1'b1;
        cfg_index <= CFG_IDX_WIDTH;
        cfg_wdata <= 13'(w);
        @(posedge aclk);
        cfg_index <= CFG_IDX_HEIGHT;
        cfg_wdata <= 13'(h);
        @(posedge aclk);
        cfg_we <= 1'b0;
        img_w = w;
        img_h = h;
        size_settings++;
    endtask

    // One RLE8 code with random content; now and then a stray word or restart.
    task automatic send_code();
        int unsigned pick;
        int unsigned n;
        if ($urandom_range(99) < 3)
            soi_next = 1'b1;
        pick = $urandom_range(99);
        if (pick < 36) begin
            n = $urandom_range(1) ? $urandom_range(1, 8) : $urandom_range(1, 255);
            send_pair(8'(n), 8'($urandom));
        end else if (pick < 52) begin
            n = ($urandom_range(19) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
            send_pair(8'd0, 8'(n));
            repeat (n) send_byte(8'($urandom));
            if (n[0])
                send_byte(8'($urandom));
        end else if (pick < 67) begin
            send_pair(8'd0, ESC_EOL);
        end else if (pick < 84) begin
            send_pair(8'd0, ESC_DELTA);
            send_byte($urandom_range(1) ? 8'($urandom_range(0, 8)) : 8'($urandom));
            send_byte($urandom_range(1) ? 8'($urandom_range(0, 2)) : 8'($urandom));
        end else if (pick < 90) begin
            send_pair(8'd0, ESC_EOB);
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
            soi_next = 1'b1;
        end else begin
            // A stray word throws the parser out of step with the code stream.
            soi_next = $urandom_range(1);
            send_byte(8'($urandom));
        end
    endtask

    task automatic test_directed_codes();
        settle();
        set_dims(16, 3);
        set_idling(IDLE_NONE);
        soi_next = 1'b1;
        send_pair(8'd5, 8'hAA);
        send_pair(8'd255, 8'h55);           // runs past the right edge
        send_pair(8'd0, ESC_EOL);           // nothing left on the row
        send_pair(8'd0, 8'd3);              // odd literal group, pad follows
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(8'hFF);
        send_pair(8'd0, ESC_DELTA);         // column beyond the width
        send_pair(8'd255, 8'd0);
        send_pair(8'd0, ESC_DELTA);         // row beyond the height
        send_pair(8'd0, 8'd5);
        send_pair(8'd0, ESC_EOL);           // below the image: no fill
        send_pair(8'd0, ESC_EOB);           // empty span, still reported
        send_pair(8'd7, 8'd7);              // ignored until the next image
    endtask

    task automatic test_resize_mid_image();
        settle();
        set_idling(IDLE_BOTH);
        soi_next = 1'b1;
        send_pair(8'd0, ESC_DELTA);
        send_pair(8'd12, 8'd1);
        settle();
        // Narrowing the image leaves the cursor beyond the new right edge.
        set_dims(4, 3);
        send_pair(8'd0, ESC_DELTA);
        send_pair(8'd0, 8'd0);
        send_pair(8'd3, 8'h44);
        send_pair(8'd0, ESC_EOL);
        send_pair(8'd0, ESC_EOB);
        send_pair(8'd1, 8'd1);
    endtask

    task automatic test_random_streams();
        int unsigned w;
        int unsigned h;
        int unsigned goal;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin w = 640; h = 480; end
                1: begin w = 1; h = 1; end
                2: begin w = 4096; h = 4096; end
                3: begin w = 1; h = 4096; end
                4: begin w = 4096; h = 1; end
                7: begin w = $urandom_range(1, 4096); h = $urandom_range(1, 64); end
                default: begin w = $urandom_range(2, 40); h = $urandom_range(2, 40); end
            endcase
            settle();
            set_dims(w, h);
            set_idling(idle_mode_t'(p % 4));
            if (p == 0 || $urandom_range(1))
                soi_next = 1'b1;
            goal = live_words + WORDS_PER_PHASE;
            while (live_words < goal)
                send_code();
        end
    endtask

    always @(posedge aclk)
        m_ready <= aresetn && ($urandom_range(99) >= sink_stall_pct);

    always @(posedge aclk) begin
        cmd_t got;
        cmd_t want;
        if (aresetn && m_valid && m_ready) begin
            got.start_row = m_start_row;
            got.start_col = m_start_col;
            got.end_row = m_end_row;
            got.end_col = m_end_col;
            got.fill_value = m_fill_value;
            got.clipped = m_clipped;
            got.end_of_image = m_end_of_image;
            fills_seen++;
            if (m_clipped === 1'b1)
                clipped_seen++;
            if (m_end_of_image === 1'b1)
                eoi_seen++;
            if (pending_fills.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected fill %s", fill_text(got));
            end else begin
                want = pending_fills.pop_front();
                if (got.start_row !== want.start_row || got.start_col !== want.start_col ||
                    got.end_row !== want.end_row || got.end_col !== want.end_col ||
                    got.fill_value !== want.fill_value || got.clipped !== want.clipped ||
                    got.end_of_image !== want.end_of_image) begin
                    faults++;
                    if (faults <= 10)
                        $display("fill %0d: expected %s, got %s",
                                 fills_seen, fill_text(want), fill_text(got));
                end
            end
        end
    end

    // Ends the run if neither channel moves a word for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        restart_image();
        @(posedge aclk);
        test_directed_codes();
        test_resize_mid_image();
        test_random_streams();
        settle();
        if (pending_fills.size() != 0) begin
            faults += pending_fills.size();
            $display("%0d fill commands never arrived", pending_fills.size());
        end
        $display("Decoded %0d live code words under %0d image sizes.",
                 live_words, size_settings);
        $display("Checked %0d fill commands, %0d of them clipped and %0d ending an image.",
                 fills_seen, clipped_seen, eoi_seen);
        if (faults == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
